FILE: rtl/field_sad_decimation_selector_top_macros.svh
// assertion macros for the field sad decimation selector
`ifndef FIELD_SAD_DECIMATION_SELECTOR_TOP_MACROS_SVH
`define FIELD_SAD_DECIMATION_SELECTOR_TOP_MACROS_SVH

`ifndef SYNTHESIS

`define FSDS_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define FSDS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define FSDS_ASSERT_SAME(lbl, ante, cons)

`define FSDS_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

FILE: rtl/fsds_pkg.sv
// shared constants, types and a function of the field sad decimation selector
`default_nettype none

package fsds_pkg;

    localparam int MAX_GROUP = 16;
    localparam int SUM_WIDTH = 32;

    localparam int LUMA_W = 8;
    localparam int IDX_W  = 5;
    localparam int SKIP_W = 8;
    localparam int OUT_W  = 32;
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    typedef enum logic [2:0] {
        REG_GROUP_SIZE   = 3'd0,
        REG_INTERLACED   = 3'd1,
        REG_FORCE_ENABLE = 3'd2,
        REG_FORCED_EVEN  = 3'd3,
        REG_FORCED_ODD   = 3'd4,
        REG_SKIP_FRAMES  = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic [IDX_W-1:0]  group_size;
        logic              interlaced_mode;
        logic              force_enable;
        logic [IDX_W-1:0]  forced_even_index;
        logic [IDX_W-1:0]  forced_odd_index;
        logic [SKIP_W-1:0] skip_frames;
    } cfg_t;

    typedef struct packed {
        logic              valid;
        logic [LUMA_W-1:0] diff;
        logic              odd_line;
        logic              frame_end;
    } stage_t;

    // clips a sum to the 32-bit result field
    function automatic logic [OUT_W-1:0] sat_out(input logic [SUM_WIDTH-1:0] v);
        logic [63:0] w;
        w = 64'(v);
        sat_out = (w[63:OUT_W] != '0) ? '1 : w[OUT_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/fsds_if.sv
// word channel interfaces for pixel pairs and drop results
`default_nettype none

interface fsds_pix_if import fsds_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [LUMA_W-1:0] current_luma;
    logic [LUMA_W-1:0] previous_luma;
    logic              odd_line;
    logic              frame_end;

    modport source (output valid, current_luma, previous_luma, odd_line, frame_end,
                    input ready);
    modport sink (input valid, current_luma, previous_luma, odd_line, frame_end,
                  output ready);
endinterface

interface fsds_res_if import fsds_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] drop_even_index;
    logic [IDX_W-1:0] drop_odd_index;
    logic             field_drop;
    logic [OUT_W-1:0] min_even_sad;
    logic [OUT_W-1:0] min_odd_sad;

    modport source (output valid, drop_even_index, drop_odd_index, field_drop,
                    min_even_sad, min_odd_sad, input ready);
    modport sink (input valid, drop_even_index, drop_odd_index, field_drop,
                  min_even_sad, min_odd_sad, output ready);
endinterface

`default_nettype wire

FILE: rtl/field_sad_decimation_selector_top.sv
// top level of the field sad decimation selector
`default_nettype none

// Takes one pixel word (current and previous luma, line parity, frame end) per clock and
// reports, after the last word of each group of frames, which frame or fields to drop.
// Each word passes an input register holding its absolute difference and then the
// accumulate-and-compare logic; the drop word is registered in the result register
// as the group-ending word is taken. Throughput is one word per clock while the result
// register is free or draining; a held result stalls only the next group-ending word.
// After reset the first skip_frames+1 frames are passed without detection.
module field_sad_decimation_selector_top import fsds_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    fsds_pix_if.sink               pixel,
    fsds_res_if.source             result,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready
);

    cfg_t   cfg;
    stage_t stage;
    logic   take;

    fsds_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    fsds_in_stage u_in_stage (
        .clk   (clk),
        .rst_n (rst_n),
        .pix   (pixel),
        .take  (take),
        .stage (stage)
    );

    fsds_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .stage (stage),
        .take  (take),
        .res   (result)
    );

endmodule

`default_nettype wire

FILE: rtl/fsds_cfg.sv
// apb configuration registers
`default_nettype none

module fsds_cfg import fsds_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    output cfg_t                   cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_GROUP_SIZE:   cfg_next.group_size        = pwdata[IDX_W-1:0];
                REG_INTERLACED:   cfg_next.interlaced_mode   = pwdata[0];
                REG_FORCE_ENABLE: cfg_next.force_enable      = pwdata[0];
                REG_FORCED_EVEN:  cfg_next.forced_even_index = pwdata[IDX_W-1:0];
                REG_FORCED_ODD:   cfg_next.forced_odd_index  = pwdata[IDX_W-1:0];
                REG_SKIP_FRAMES:  cfg_next.skip_frames       = pwdata[SKIP_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_GROUP_SIZE:   prdata = DATA_W'(cfg_reg.group_size);
            REG_INTERLACED:   prdata = DATA_W'(cfg_reg.interlaced_mode);
            REG_FORCE_ENABLE: prdata = DATA_W'(cfg_reg.force_enable);
            REG_FORCED_EVEN:  prdata = DATA_W'(cfg_reg.forced_even_index);
            REG_FORCED_ODD:   prdata = DATA_W'(cfg_reg.forced_odd_index);
            REG_SKIP_FRAMES:  prdata = DATA_W'(cfg_reg.skip_frames);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.group_size        <= IDX_W'(5);
            cfg_reg.interlaced_mode   <= 1'b0;
            cfg_reg.force_enable      <= 1'b0;
            cfg_reg.forced_even_index <= IDX_W'(1);
            cfg_reg.forced_odd_index  <= IDX_W'(1);
            cfg_reg.skip_frames       <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/fsds_in_stage.sv
// input register holding the absolute difference of each accepted word
`default_nettype none

module fsds_in_stage import fsds_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    fsds_pix_if.sink    pix,
    input  wire logic   take,
    output stage_t      stage
);

    logic              valid_reg;
    logic              valid_next;
    logic [LUMA_W-1:0] diff_reg;
    logic [LUMA_W-1:0] diff_next;
    logic              odd_reg;
    logic              fend_reg;
    logic              accept;

    assign pix.ready = !valid_reg || take;
    assign accept    = pix.valid && pix.ready;

    assign diff_next = (pix.current_luma >= pix.previous_luma)
                     ? pix.current_luma - pix.previous_luma
                     : pix.previous_luma - pix.current_luma;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b0;
        end
        if (accept)
        begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            diff_reg <= diff_next;
            odd_reg  <= pix.odd_line;
            fend_reg <= pix.frame_end;
        end
    end

    assign stage.valid     = valid_reg;
    assign stage.diff      = diff_reg;
    assign stage.odd_line  = odd_reg;
    assign stage.frame_end = fend_reg;

endmodule

`default_nettype wire

FILE: rtl/fsds_core.sv
// difference accumulators, per-group minimum search and result register
`default_nettype none

`include "field_sad_decimation_selector_top_macros.svh"

module fsds_core import fsds_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire cfg_t  cfg,
    input  wire stage_t stage,
    output logic       take,
    fsds_res_if.source res
);

    localparam logic [IDX_W-1:0]  MAX_IDX   = IDX_W'(MAX_GROUP);
    localparam logic [IDX_W-1:0]  IDX_ONE   = IDX_W'(1);
    localparam logic [IDX_W-1:0]  IDX_TWO   = IDX_W'(2);
    localparam logic [SKIP_W:0]   SKIP_DONE = {1'b1, SKIP_W'(0)};

    function automatic logic [SUM_WIDTH-1:0] sat_add(input logic [SUM_WIDTH-1:0] a,
                                                     input logic [SUM_WIDTH-1:0] b);
        logic [SUM_WIDTH:0] s;
        s = {1'b0, a} + {1'b0, b};
        sat_add = s[SUM_WIDTH] ? '1 : s[SUM_WIDTH-1:0];
    endfunction

    function automatic logic [IDX_W-1:0] clamp_idx(input logic [IDX_W-1:0] v,
                                                   input logic [IDX_W-1:0] g);
        if (v == '0)
            clamp_idx = IDX_ONE;
        else if (v > g)
            clamp_idx = g;
        else
            clamp_idx = v;
    endfunction

    // running sums and search state
    logic [SUM_WIDTH-1:0] even_acc_reg, even_acc_next;
    logic [SUM_WIDTH-1:0] odd_acc_reg, odd_acc_next;
    logic [SUM_WIDTH-1:0] tot_acc_reg, tot_acc_next;
    logic [IDX_W-1:0]     pos_reg, pos_next;
    logic [SKIP_W:0]      skip_reg, skip_next;
    logic [SUM_WIDTH-1:0] best_even_reg, best_even_next;
    logic [SUM_WIDTH-1:0] best_odd_reg, best_odd_next;
    logic [IDX_W-1:0]     best_even_frame_reg, best_even_frame_next;
    logic [IDX_W-1:0]     best_odd_frame_reg, best_odd_frame_next;

    // result register
    logic                 res_valid_reg, res_valid_next;
    logic [IDX_W-1:0]     res_even_idx_reg;
    logic [IDX_W-1:0]     res_odd_idx_reg;
    logic                 res_field_drop_reg;
    logic [OUT_W-1:0]     res_min_even_reg;
    logic [OUT_W-1:0]     res_min_odd_reg;

    logic [SUM_WIDTH-1:0] diff_ext;
    logic [SUM_WIDTH-1:0] even_add, odd_add, tot_add;
    logic [IDX_W-1:0]     grp;
    logic [IDX_W-1:0]     pos;
    logic                 first;
    logic                 detecting;
    logic                 emit;
    logic                 load;
    logic [SUM_WIDTH-1:0] even_cand;
    logic                 upd_even, upd_odd;
    logic [SUM_WIDTH-1:0] new_best_even, new_best_odd;
    logic [IDX_W-1:0]     new_even_frame, new_odd_frame;
    logic [IDX_W-1:0]     force_even, force_odd;
    logic [IDX_W-1:0]     de, dodd;
    logic [SUM_WIDTH-1:0] se, so;

    // only a group-ending word waits for the result register
    assign take = stage.valid && (!emit || !res_valid_reg || res.ready);

    assign diff_ext = SUM_WIDTH'(stage.diff);
    assign even_add = sat_add(even_acc_reg, stage.odd_line ? '0 : diff_ext);
    assign odd_add  = sat_add(odd_acc_reg, stage.odd_line ? diff_ext : '0);
    // combined sum kept in its own saturating register
    assign tot_add  = sat_add(tot_acc_reg, diff_ext);

    assign grp = (cfg.group_size < IDX_TWO) ? IDX_TWO
               : (cfg.group_size > MAX_IDX) ? MAX_IDX : cfg.group_size;
    assign pos   = (pos_reg == '0) ? IDX_ONE : pos_reg;
    assign first = (pos == IDX_ONE);

    assign detecting = skip_reg[SKIP_W];
    assign emit      = detecting && stage.frame_end && (pos >= grp);
    assign load      = take && emit;

    assign even_cand = cfg.interlaced_mode ? even_add : tot_add;
    assign upd_even  = first || (even_cand < best_even_reg);
    assign upd_odd   = cfg.interlaced_mode && (first || (odd_add < best_odd_reg));

    assign new_best_even  = upd_even ? even_cand : best_even_reg;
    assign new_even_frame = upd_even ? pos : best_even_frame_reg;
    assign new_best_odd   = upd_odd ? odd_add : best_odd_reg;
    assign new_odd_frame  = upd_odd ? pos : best_odd_frame_reg;

    assign force_even = clamp_idx(cfg.forced_even_index, grp);
    assign force_odd  = (cfg.forced_odd_index == '0) ? force_even
                      : clamp_idx(cfg.forced_odd_index, grp);

    always_comb
    begin
        if (cfg.force_enable)
        begin
            de   = force_even;
            dodd = force_odd;
            se   = '0;
            so   = '0;
        end
        else
        begin
            de   = new_even_frame;
            dodd = new_odd_frame;
            se   = new_best_even;
            so   = new_best_odd;
        end
        if (!cfg.interlaced_mode)
        begin
            dodd = de;
            so   = '0;
        end
    end

    always_comb
    begin
        even_acc_next        = even_acc_reg;
        odd_acc_next         = odd_acc_reg;
        tot_acc_next         = tot_acc_reg;
        pos_next             = pos_reg;
        skip_next            = skip_reg;
        best_even_next       = best_even_reg;
        best_odd_next        = best_odd_reg;
        best_even_frame_next = best_even_frame_reg;
        best_odd_frame_next  = best_odd_frame_reg;
        if (take)
        begin
            if (!stage.frame_end)
            begin
                even_acc_next = even_add;
                odd_acc_next  = odd_add;
                tot_acc_next  = tot_add;
            end
            else
            begin
                even_acc_next = '0;
                odd_acc_next  = '0;
                tot_acc_next  = '0;
                if (!detecting)
                begin
                    skip_next = (skip_reg >= {1'b0, cfg.skip_frames}) ? SKIP_DONE
                              : skip_reg + 1'b1;
                end
                else if (emit)
                begin
                    pos_next             = IDX_ONE;
                    best_even_next       = '1;
                    best_odd_next        = '1;
                    best_even_frame_next = IDX_ONE;
                    best_odd_frame_next  = IDX_ONE;
                end
                else
                begin
                    pos_next             = pos + 1'b1;
                    best_even_next       = new_best_even;
                    best_odd_next        = new_best_odd;
                    best_even_frame_next = new_even_frame;
                    best_odd_frame_next  = new_odd_frame;
                end
            end
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (res.ready)
        begin
            res_valid_next = 1'b0;
        end
        if (load)
        begin
            res_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            even_acc_reg        <= '0;
            odd_acc_reg         <= '0;
            tot_acc_reg         <= '0;
            pos_reg             <= IDX_ONE;
            skip_reg            <= '0;
            best_even_reg       <= '1;
            best_odd_reg        <= '1;
            best_even_frame_reg <= IDX_ONE;
            best_odd_frame_reg  <= IDX_ONE;
            res_valid_reg       <= 1'b0;
        end
        else
        begin
            even_acc_reg        <= even_acc_next;
            odd_acc_reg         <= odd_acc_next;
            tot_acc_reg         <= tot_acc_next;
            pos_reg             <= pos_next;
            skip_reg            <= skip_next;
            best_even_reg       <= best_even_next;
            best_odd_reg        <= best_odd_next;
            best_even_frame_reg <= best_even_frame_next;
            best_odd_frame_reg  <= best_odd_frame_next;
            res_valid_reg       <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_even_idx_reg   <= de;
            res_odd_idx_reg    <= dodd;
            res_field_drop_reg <= cfg.interlaced_mode && (de != dodd);
            res_min_even_reg   <= sat_out(se);
            res_min_odd_reg    <= sat_out(so);
        end
    end

    assign res.valid           = res_valid_reg;
    assign res.drop_even_index = res_even_idx_reg;
    assign res.drop_odd_index  = res_odd_idx_reg;
    assign res.field_drop      = res_field_drop_reg;
    assign res.min_even_sad    = res_min_even_reg;
    assign res.min_odd_sad     = res_min_odd_reg;

    `FSDS_ASSERT_SAME(a_pos_range, 1'b1, (pos_reg != '0) && (pos_reg <= MAX_IDX))
    `FSDS_ASSERT_SAME(a_no_result_in_skip, !skip_reg[SKIP_W], !load)
    `FSDS_ASSERT_NEXT(a_group_restart, load, (pos_reg == IDX_ONE) && res_valid_reg)
    `FSDS_ASSERT_NEXT(a_index_range, load,
                      (res_even_idx_reg != '0) && (res_even_idx_reg <= MAX_IDX))
    `FSDS_ASSERT_NEXT(a_progressive_whole, load && !cfg.interlaced_mode,
                      !res_field_drop_reg && (res_min_odd_reg == '0))

endmodule

`default_nettype wire
